[hw/rtl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants for the background accumulator
// Action, method and register codes, sizes and the sequencer state type.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int unsigned MAX_PIXELS_DEF      = 1024;
   localparam int unsigned BIN_COUNT_WIDTH_DEF = 16;
   localparam int unsigned SUM_WIDTH_DEF       = 32;

   localparam int unsigned NUM_CH       = 3;
   localparam int unsigned BIN_W        = 8;
   localparam int unsigned SAMPLE_W     = 8;
   localparam int unsigned PIX_IDX_W    = 10;
   localparam int unsigned FRAME_PIX_W  = 11;
   localparam int unsigned FRAME_CNT_W  = 24;
   localparam int unsigned CSR_ADDR_W   = 2;
   localparam int unsigned CSR_DATA_W   = 11;
   localparam logic [SAMPLE_W-1:0] START_MIN = 8'd255;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      METH_MEAN = 2'd0,
      METH_MODE = 2'd1,
      METH_MIN  = 2'd2,
      METH_MAX  = 2'd3
   } method_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_METHOD      = 2'd0,
      REG_THREE_CH    = 2'd1,
      REG_FRAME_PIXELS = 2'd2
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_CLR_PIX,
      ST_CLR_HIST,
      ST_RD_RD,
      ST_RD_DATA,
      ST_RD_DIV,
      ST_MODE_SCAN,
      ST_MODE_LAST,
      ST_OUT
   } state_type;

endpackage

[hw/rtl/per_pixel_background_accumulator.sv]
// ----------------------------------------------------------------------------
// per_pixel_background_accumulator: per-pixel background model
// Mean, histogram mode, minimum or maximum per pixel and channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries requests: tuser = action, tdata = pixel index and three
//   samples, tlast = end of frame (counts one frame on an add).
//   rsp_* returns one result per read request: tdata = three 8-bit channel
//   values, tuser = no-frames flag. csr_* writes method, channel count and
//   frame size; the user must do so only while the block is idle, which the
//   block itself does not enforce. Requests are served one at a time
//   through the single-port pixel and bin memories: an add or a min/max read
//   works channel by channel; a clear writes the pixel store, then the bins;
//   a mean read goes through the bit-serial divider; a mode read scans the
//   bin memory one bin per cycle; the result register is then loaded.
//   After reset a clearing pass writes zero to all MAX_PIXELS*3*256 bin
//   entries (one per cycle, the pixel store alongside); no request is taken
//   until it ends. A new request is taken while a result still waits;
//   a read result waits in its own stage while rsp_tready is low.
// ----------------------------------------------------------------------------
module per_pixel_background_accumulator
   import pba_pkg::*;
#(
   parameter int unsigned MAX_PIXELS      = MAX_PIXELS_DEF,
   parameter int unsigned BIN_COUNT_WIDTH = BIN_COUNT_WIDTH_DEF,
   parameter int unsigned SUM_WIDTH       = SUM_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // pixel_index, sample_c0, c1, c2
   input  logic [1:0]            req_tuser,  // action
   input  logic                  req_tlast,  // end_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,  // result_c0, result_c1, result_c2
   output logic                  rsp_tuser,  // no_frames
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned PIX_DEPTH  = MAX_PIXELS * NUM_CH;
   localparam int unsigned PIX_AW     = $clog2(PIX_DEPTH);
   localparam int unsigned HIST_DEPTH = PIX_DEPTH * (1 << BIN_W);
   localparam int unsigned HIST_AW    = PIX_AW + BIN_W;
   localparam logic [SUM_WIDTH-1:0]       SUM_MAX = '1;
   localparam logic [BIN_COUNT_WIDTH-1:0] BIN_MAX = '1;
   localparam logic [FRAME_CNT_W-1:0]     FRAME_MAX = '1;

   // configuration
   method_type              method_ff;
   logic                    three_ff;
   logic [FRAME_PIX_W-1:0]  fpix_ff;
   logic [FRAME_CNT_W-1:0]  frame_ff, frame_in;

   // sequencer
   state_type               state_ff, state_in;
   logic [HIST_AW-1:0]      init_ff, init_in;
   logic [1:0]              ch_ff, ch_in;
   logic [BIN_W-1:0]        bin_ff, bin_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [BIN_W-1:0]        rd_bin_ff, rd_bin_in;
   logic [BIN_COUNT_WIDTH-1:0] best_ff, best_in;
   logic [BIN_W-1:0]        idx_ff, idx_in;

   // latched request
   logic [PIX_AW-1:0]       kbase_ff, kbase_in;
   logic [SAMPLE_W-1:0]     smp_ff [NUM_CH];
   logic [SAMPLE_W-1:0]     smp_in [NUM_CH];

   // results and output stage
   logic [SAMPLE_W-1:0]     res_ff [NUM_CH];
   logic [SAMPLE_W-1:0]     res_in [NUM_CH];
   logic                    nof_ff, nof_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [23:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;

   // memory ports
   logic                       pix_we;
   logic [PIX_AW-1:0]          pix_addr;
   logic [SUM_WIDTH-1:0]       pix_wdata, pix_rdata;
   logic                       hist_we;
   logic [HIST_AW-1:0]         hist_addr;
   logic [BIN_COUNT_WIDTH-1:0] hist_wdata, hist_rdata;

   logic                    div_start, div_done;
   logic [SAMPLE_W-1:0]     div_q;

   logic                    accept;
   action_type              req_act;
   logic [PIX_IDX_W-1:0]    req_px;
   logic                    req_valid_px;
   logic [PIX_AW-1:0]       req_px_ext;
   logic [PIX_AW-1:0]       k;
   logic [SAMPLE_W-1:0]     smp_cur;
   logic                    last_ch;
   logic [SUM_WIDTH:0]      sum_ext;
   logic [SAMPLE_W-1:0]     pix_sat;
   logic                    take;

   pba_ram #(.WIDTH(SUM_WIDTH), .DEPTH(PIX_DEPTH)) u_pix_ram (
      .clock (clock),
      .we    (pix_we),
      .addr  (pix_addr),
      .wdata (pix_wdata),
      .rdata (pix_rdata)
   );

   pba_ram #(.WIDTH(BIN_COUNT_WIDTH), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .addr  (hist_addr),
      .wdata (hist_wdata),
      .rdata (hist_rdata)
   );

   pba_divider #(.SUM_WIDTH(SUM_WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pix_rdata),
      .divisor  (frame_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // decode the incoming request
   assign req_act      = action_type'(req_tuser);
   assign req_px       = req_tdata[9:0];
   assign req_valid_px = ({1'b0, req_px} < fpix_ff) && (32'(req_px) < MAX_PIXELS);
   assign req_px_ext   = PIX_AW'(req_px);
   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;

   assign k        = kbase_ff + PIX_AW'(ch_ff);
   assign last_ch  = three_ff ? (ch_ff == 2'd2) : (ch_ff == 2'd0);
   assign sum_ext  = {1'b0, pix_rdata} + (SUM_WIDTH + 1)'(smp_cur);
   assign pix_sat  = (|(pix_rdata >> SAMPLE_W)) ? START_MIN : pix_rdata[SAMPLE_W-1:0];
   assign take     = (rd_bin_ff == '0) || (hist_rdata > best_ff);

   always_comb begin
      case (ch_ff)
         2'd0:    smp_cur = smp_ff[0];
         2'd1:    smp_cur = smp_ff[1];
         2'd2:    smp_cur = smp_ff[2];
         default: smp_cur = smp_ff[0];
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= METH_MEAN;
         three_ff  <= 1'b0;
         fpix_ff   <= FRAME_PIX_W'(1024);
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_METHOD:       method_ff <= method_type'(csr_wdata[1:0]);
            REG_THREE_CH:     three_ff  <= csr_wdata[0];
            REG_FRAME_PIXELS: fpix_ff   <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // sequencer: next state, memory accesses and results
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      ch_in        = ch_ff;
      bin_in       = bin_ff;
      rd_vld_in    = 1'b0;
      rd_bin_in    = bin_ff;
      best_in      = best_ff;
      idx_in       = idx_ff;
      kbase_in     = kbase_ff;
      smp_in       = smp_ff;
      res_in       = res_ff;
      nof_in       = nof_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      pix_we       = 1'b0;
      pix_addr     = k;
      pix_wdata    = '0;
      hist_we      = 1'b0;
      hist_addr    = {k, bin_ff};
      hist_wdata   = '0;
      div_start    = 1'b0;

      case (state_ff)
         ST_INIT: begin
            // sweep zero through both memories
            hist_we   = 1'b1;
            hist_addr = init_ff;
            pix_addr  = PIX_AW'(init_ff);
            pix_we    = (32'(init_ff) < PIX_DEPTH);
            init_in   = init_ff + 1'b1;
            if (32'(init_ff) == HIST_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kbase_in  = (req_px_ext << 1) + req_px_ext;
               smp_in[0] = req_tdata[17:10];
               smp_in[1] = req_tdata[25:18];
               smp_in[2] = req_tdata[33:26];
               ch_in     = 2'd0;
               bin_in    = '0;
               case (req_act)
                  ACT_ADD: begin
                     if (req_tlast && (frame_ff != FRAME_MAX)) begin
                        frame_in = frame_ff + 1'b1;
                     end
                     if (req_valid_px) begin
                        state_in = ST_ADD_RD;
                     end
                  end
                  ACT_CLEAR: begin
                     if (req_valid_px) begin
                        state_in = ST_CLR_PIX;
                     end
                  end
                  ACT_READ: begin
                     res_in[0] = '0;
                     res_in[1] = '0;
                     res_in[2] = '0;
                     nof_in    = 1'b0;
                     if (!req_valid_px) begin
                        state_in = ST_OUT;
                     end else if (method_ff == METH_MEAN && frame_ff == '0) begin
                        nof_in   = 1'b1;
                        state_in = ST_OUT;
                     end else if (method_ff == METH_MODE) begin
                        state_in = ST_MODE_SCAN;
                     end else begin
                        state_in = ST_RD_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_RD: begin
            // fetch the entry to update
            hist_addr = {k, smp_cur};
            state_in  = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            // modify and write back
            case (method_ff)
               METH_MEAN: begin
                  pix_we    = 1'b1;
                  pix_wdata = sum_ext[SUM_WIDTH] ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];
               end
               METH_MODE: begin
                  hist_addr  = {k, smp_cur};
                  hist_we    = (hist_rdata != BIN_MAX);
                  hist_wdata = hist_rdata + 1'b1;
               end
               METH_MIN: begin
                  pix_we    = (SUM_WIDTH'(smp_cur) < pix_rdata);
                  pix_wdata = SUM_WIDTH'(smp_cur);
               end
               default: begin
                  pix_we    = (SUM_WIDTH'(smp_cur) > pix_rdata);
                  pix_wdata = SUM_WIDTH'(smp_cur);
               end
            endcase
            if (last_ch) begin
               state_in = ST_IDLE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_ADD_RD;
            end
         end
         ST_CLR_PIX: begin
            // write the start value to all three channels
            pix_we    = 1'b1;
            pix_wdata = (method_ff == METH_MIN) ? SUM_WIDTH'(START_MIN) : '0;
            if (ch_ff == 2'd2) begin
               ch_in    = 2'd0;
               state_in = ST_CLR_HIST;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_CLR_HIST: begin
            // zero the 256 bins of each channel
            hist_we = 1'b1;
            bin_in  = bin_ff + 1'b1;
            if (bin_ff == '1) begin
               if (ch_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         ST_RD_RD: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            if (method_ff == METH_MEAN) begin
               div_start = 1'b1;
               state_in  = ST_RD_DIV;
            end else begin
               res_in[ch_ff] = pix_sat;
               ch_in    = ch_ff + 1'b1;
               state_in = last_ch ? ST_OUT : ST_RD_RD;
            end
         end
         ST_RD_DIV: begin
            if (div_done) begin
               res_in[ch_ff] = div_q;
               ch_in    = ch_ff + 1'b1;
               state_in = last_ch ? ST_OUT : ST_RD_RD;
            end
         end
         ST_MODE_SCAN: begin
            // issue one bin read per cycle, compare the previous one
            rd_vld_in = 1'b1;
            rd_bin_in = bin_ff;
            bin_in    = bin_ff + 1'b1;
            if (rd_vld_ff && take) begin
               best_in = hist_rdata;
               idx_in  = rd_bin_ff;
            end
            if (bin_ff == '1) begin
               state_in = ST_MODE_LAST;
            end
         end
         ST_MODE_LAST: begin
            bin_in = '0;
            res_in[ch_ff] = (hist_rdata > best_ff) ? rd_bin_ff : idx_ff;
            ch_in    = ch_ff + 1'b1;
            state_in = last_ch ? ST_OUT : ST_MODE_SCAN;
         end
         ST_OUT: begin
            // load the output stage once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[2], res_ff[1], res_ff[0]};
               rsp_user_in  = nof_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         frame_ff     <= frame_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
      ch_ff       <= ch_in;
      bin_ff      <= bin_in;
      rd_bin_ff   <= rd_bin_in;
      best_ff     <= best_in;
      idx_ff      <= idx_in;
      kbase_ff    <= kbase_in;
      smp_ff      <= smp_in;
      res_ff      <= res_in;
      nof_ff      <= nof_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // a result appears only when the output stage is loaded
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result without a finished read");

   // no request taken during the clearing pass
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !req_tready)
      else $error("request taken during clearing pass");

   // frame counter never goes backward
   a_frame_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (frame_ff >= $past(frame_ff)))
      else $error("frame counter decreased");

   // divider only started for a mean read
   a_div_mean: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (method_ff == METH_MEAN) && (frame_ff != '0))
      else $error("divider started outside a mean read");

endmodule

[hw/rtl/pba_ram.sv]
// ----------------------------------------------------------------------------
// pba_ram: generic single-port synchronous RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module pba_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read the addressed word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/pba_divider.sv]
// ----------------------------------------------------------------------------
// pba_divider: bit-serial mean divider
// Restoring division, one quotient bit per cycle, then round half to even
// and clamp to 8 bits.
// ----------------------------------------------------------------------------
module pba_divider
   import pba_pkg::*;
#(
   parameter int unsigned SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [SUM_WIDTH-1:0]   dividend,
   input  logic [FRAME_CNT_W-1:0] divisor,
   output logic                   done,
   output logic [SAMPLE_W-1:0]    quotient
);

   localparam int unsigned CNT_W = $clog2(SUM_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   fin_ff, fin_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SUM_WIDTH-1:0]   q_ff, q_in;
   logic [FRAME_CNT_W-1:0] rem_ff, rem_in;
   logic [FRAME_CNT_W-1:0] d_ff, d_in;
   logic [SAMPLE_W-1:0]    res_ff, res_in;
   logic [FRAME_CNT_W:0]   rem_sh;
   logic [FRAME_CNT_W:0]   twice;
   logic                   up;

   // one restoring step per cycle, rounding on the final cycle
   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      res_in  = res_ff;
      rem_sh  = {rem_ff, q_ff[SUM_WIDTH-1]};
      twice   = {rem_ff, 1'b0};
      up      = (twice > {1'b0, d_ff}) || ((twice == {1'b0, d_ff}) && q_ff[0]);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(SUM_WIDTH)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
            if ((|(q_ff >> SAMPLE_W)) || (q_ff[SAMPLE_W-1:0] == START_MIN)) begin
               res_in = START_MIN;
            end else begin
               res_in = q_ff[SAMPLE_W-1:0] + SAMPLE_W'(up);
            end
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (rem_sh >= {1'b0, d_ff}) begin
               rem_in = FRAME_CNT_W'(rem_sh - {1'b0, d_ff});
               q_in   = {q_ff[SUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[FRAME_CNT_W-1:0];
               q_in   = {q_ff[SUM_WIDTH-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      res_ff <= res_in;
   end

   assign done     = fin_ff;
   assign quotient = res_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: per-pixel background accumulator
// Predicts every read result of the accumulator from a local copy of the
// pixel store, the histogram bins and the frame counter, and checks each
// returned result in order. Directed requests cover the corner cases; random
// phases then run under changing method, channel count and frame size, with
// random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import pba_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam int unsigned DRAIN_WAIT  = 800;
   localparam int unsigned HOLD_CYCLES = 3000;
   localparam int unsigned NUM_PIX     = MAX_PIXELS_DEF;

   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      logic       no_frames;
   } bg_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;   // pixel_index, sample_c0, c1, c2
   logic [1:0]            req_tuser = '0;   // action
   logic                  req_tlast = 1'b0; // end_of_frame
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;        // result_c0, result_c1, result_c2
   logic                  rsp_tuser;        // no_frames
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the accumulator state
   longint unsigned pix_acc[NUM_PIX*NUM_CH];
   bit [15:0]       bin_cnt[NUM_PIX*NUM_CH*256];
   int unsigned     frames_seen;
   method_type      cur_method;
   bit              cur_three_ch;
   int unsigned     cur_frame_pix;

   bg_result_t  pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          quiet_phase = 1'b0;
   bit          hold_request = 1'b0;

   per_pixel_background_accumulator dut (.*);

   always #5 clock = ~clock;

   // abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            held = 0;
            rsp_tready <= 1'b0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_request = 1'b0;
         end
         rsp_tready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 15);
      end
   end

   // compare each returned result with the oldest expectation
   always @(posedge clock) begin
      bg_result_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tuser};
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.c0 !== want.c0) begin
               $display("%0t: result_c0 expected %0d actual %0d", $time, want.c0, got.c0);
               mismatch_count++;
            end
            if (got.c1 !== want.c1) begin
               $display("%0t: result_c1 expected %0d actual %0d", $time, want.c1, got.c1);
               mismatch_count++;
            end
            if (got.c2 !== want.c2) begin
               $display("%0t: result_c2 expected %0d actual %0d", $time, want.c2, got.c2);
               mismatch_count++;
            end
            if (got.no_frames !== want.no_frames) begin
               $display("%0t: no_frames expected %0d actual %0d", $time,
                        want.no_frames, got.no_frames);
               mismatch_count++;
            end
         end
      end
   end

   function automatic logic [7:0] clip255(longint unsigned v);
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] rounded_mean(longint unsigned sum, longint unsigned n);
      longint unsigned q, r;
      q = sum / n;
      r = sum % n;
      if (2 * r > n || (2 * r == n && q[0])) q++;
      return clip255(q);
   endfunction

   function automatic logic [7:0] peak_bin(int unsigned base);
      bit [15:0] best;
      logic [7:0] idx;
      best = bin_cnt[base];
      idx = 0;
      for (int v = 1; v < 256; v++)
         if (bin_cnt[base + v] > best) begin
            best = bin_cnt[base + v];
            idx = 8'(v);
         end
      return idx;
   endfunction

   // update the state copy for one accepted request; queue a read result
   task automatic accumulate(action_type act, int unsigned px, logic [7:0] smp[3], bit eof);
      bit in_frame;
      int unsigned nch, k;
      bg_result_t res;
      in_frame = (px < cur_frame_pix) && (px < NUM_PIX);
      nch = cur_three_ch ? 3 : 1;
      res = '0;
      case (act)
         ACT_ADD: begin
            if (in_frame)
               for (int c = 0; c < nch; c++) begin
                  k = px * NUM_CH + c;
                  case (cur_method)
                     METH_MEAN: pix_acc[k] = (pix_acc[k] + smp[c] > 64'hFFFF_FFFF) ?
                                             64'hFFFF_FFFF : pix_acc[k] + smp[c];
                     METH_MODE: if (bin_cnt[k*256 + smp[c]] != 16'hFFFF)
                                   bin_cnt[k*256 + smp[c]]++;
                     METH_MIN:  if (smp[c] < pix_acc[k]) pix_acc[k] = smp[c];
                     default:   if (smp[c] > pix_acc[k]) pix_acc[k] = smp[c];
                  endcase
               end
            if (eof && frames_seen < 24'hFFFFFF) frames_seen++;
         end
         ACT_CLEAR: begin
            if (in_frame)
               for (int c = 0; c < NUM_CH; c++) begin
                  k = px * NUM_CH + c;
                  pix_acc[k] = (cur_method == METH_MIN) ? START_MIN : 0;
                  for (int v = 0; v < 256; v++) bin_cnt[k*256 + v] = 0;
               end
         end
         ACT_READ: begin
            if (in_frame) begin
               if (cur_method == METH_MEAN && frames_seen == 0) res.no_frames = 1'b1;
               else
                  for (int c = 0; c < nch; c++) begin
                     k = px * NUM_CH + c;
                     case (cur_method)
                        METH_MEAN: res[24 - 8*c -: 8] = rounded_mean(pix_acc[k], frames_seen);
                        METH_MODE: res[24 - 8*c -: 8] = peak_bin(k * 256);
                        default:   res[24 - 8*c -: 8] = clip255(pix_acc[k]);
                     endcase
                  end
            end
            pending_results.push_back(res);
         end
         default: ;
      endcase
   endtask

   // offer one request and hold it until accepted
   task automatic send_request(logic [1:0] act, int unsigned px, logic [7:0] s0,
                               logic [7:0] s1, logic [7:0] s2, bit eof);
      logic [7:0] smp[3];
      smp = '{s0, s1, s2};
      while (!quiet_phase && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tlast  <= eof;
      req_tdata  <= {6'b0, s2, s1, s0, px[9:0]};
      do @(posedge clock); while (!req_tready);
      accumulate(action_type'(act), px[9:0], smp, eof);
   endtask

   // drain outstanding results and let any clear finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, int unsigned val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_METHOD:   cur_method = method_type'(val[1:0]);
         REG_THREE_CH: cur_three_ch = val[0];
         default:      cur_frame_pix = val[10:0];
      endcase
   endtask

   task automatic set_mode(method_type m, bit three, int unsigned fp);
      wait_idle();
      write_reg(REG_METHOD, m);
      write_reg(REG_THREE_CH, three);
      write_reg(REG_FRAME_PIXELS, fp);
   endtask

   // corner cases of each method
   task automatic test_directed();
      set_mode(METH_MEAN, 1'b0, 1024);
      send_request(ACT_READ, 0, 0, 0, 0, 0);           // no frames yet
      send_request(ACT_ADD, 0, 255, 255, 255, 1);
      send_request(ACT_ADD, 0, 0, 0, 0, 1);
      send_request(ACT_READ, 0, 0, 0, 0, 0);           // half rounds to even
      send_request(2'd3, 1023, 255, 255, 255, 1);      // unknown action
      send_request(ACT_ADD, 1023, 255, 255, 255, 0);
      send_request(ACT_READ, 1023, 0, 0, 0, 0);
      set_mode(METH_MODE, 1'b1, 1024);
      send_request(ACT_CLEAR, 5, 0, 0, 0, 0);
      send_request(ACT_ADD, 5, 7, 9, 255, 0);
      send_request(ACT_ADD, 5, 9, 7, 0, 0);
      send_request(ACT_ADD, 5, 9, 7, 0, 0);
      send_request(ACT_READ, 5, 0, 0, 0, 0);           // the most frequent bin per channel wins
      set_mode(METH_MIN, 1'b1, 1024);
      send_request(ACT_CLEAR, 6, 0, 0, 0, 0);
      send_request(ACT_ADD, 6, 200, 0, 255, 0);
      send_request(ACT_ADD, 6, 100, 50, 255, 0);
      send_request(ACT_READ, 6, 0, 0, 0, 0);
      set_mode(METH_MAX, 1'b1, 1024);
      send_request(ACT_ADD, 6, 255, 1, 0, 0);
      send_request(ACT_READ, 6, 0, 0, 0, 0);           // flag stays low here
      set_mode(METH_MEAN, 1'b0, 1);
      send_request(ACT_ADD, 3, 80, 0, 0, 1);           // out of range, frame counts
      send_request(ACT_CLEAR, 3, 0, 0, 0, 0);
      send_request(ACT_READ, 3, 0, 0, 0, 0);           // out of range reads zero
      send_request(ACT_READ, 0, 0, 0, 0, 0);
   endtask

   // random phases: clear a small pixel set, accumulate, read, with noise
   task automatic test_random();
      int unsigned fp, base, px, roll;
      int unsigned set_pix[6];
      for (int phase = 0; phase < 20; phase++) begin
         case ($urandom_range(0, 4))
            0: fp = 1;
            1: fp = 1024;
            2: fp = $urandom_range(1, 16);
            default: fp = $urandom_range(1, 1024);
         endcase
         set_mode(method_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), fp);
         quiet_phase = (phase == 5);
         if (phase == 3) hold_request = 1'b1;
         base = $urandom_range(0, (fp > 6) ? fp - 6 : 0);
         foreach (set_pix[i]) set_pix[i] = (base + i) % 1024;
         foreach (set_pix[i])
            if ($urandom_range(0, 9) != 0) send_request(ACT_CLEAR, set_pix[i], 0, 0, 0, 0);
         for (int n = 0; n < 74; n++) begin
            roll = $urandom_range(0, 99);
            px = set_pix[$urandom_range(0, 5)];
            if (roll < 70)
               send_request(ACT_ADD, px, 8'($urandom), 8'($urandom), 8'($urandom),
                            $urandom_range(0, 4) == 0);
            else if (roll < 82)
               send_request(ACT_READ, px, 8'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom));
            else if (roll < 85)
               send_request(ACT_CLEAR, px, 8'($urandom), 8'($urandom), 8'($urandom),
                            1'($urandom));
            else
               send_request(2'($urandom_range(0, 3)), $urandom_range(0, 1023),
                            8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
         end
         quiet_phase = 1'b0;
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (pix_acc[i]) pix_acc[i] = 0;
      frames_seen   = 0;
      cur_method    = METH_MEAN;
      cur_three_ch  = 1'b0;
      cur_frame_pix = 1024;
      @(posedge clock);
      test_directed();
      test_random();
      wait_idle();
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
